@@ src/mmaw_pkg.sv @@
// ----------------------------------------------------------------------------
// mmaw_pkg
// Shared types, address constants and the CRC helper of the multiply, divide
// and CRC window.
// ----------------------------------------------------------------------------
package mmaw_pkg;

  // Backing store of the window.
  localparam int RamWords = 8192;
  localparam int RamAw    = $clog2(RamWords);
  typedef logic [RamAw-1:0] ram_addr_t;

  // Bus addresses.
  localparam logic [15:0] CrcPort     = 16'h9FFC;
  localparam logic [15:0] AccOffAddr  = 16'h8034;
  localparam logic [15:0] AccOnAddr   = 16'h8033;
  localparam logic [15:0] ZeroAddr    = 16'h8023;
  localparam logic [15:0] LastRowAddr = 16'h8024;
  localparam logic [11:0] OpPage      = 12'h9F8;
  localparam logic [3:0]  OpLastLow   = 4'hB;
  localparam logic [2:0]  WinTop      = 3'b100;

  // Magic words and CRC polynomial.
  localparam logic [15:0] AccOffMagic = 16'h6A7A;
  localparam logic [15:0] AccOnMagic  = 16'h4A5A;
  localparam logic [15:0] CrcPoly     = 16'hAD52;

  // RAM word addresses.
  localparam ram_addr_t CrcWord      = 13'h1FFD;
  localparam ram_addr_t ResLo        = 13'h1F8E;
  localparam ram_addr_t ResHi        = 13'h1F8F;
  localparam ram_addr_t OperandBase  = 13'h1F80;
  localparam ram_addr_t OffMagicWord = 13'h0034;
  localparam ram_addr_t OnMagicWord  = 13'h0033;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CfgAccelStart   = 2'd0,
    CfgFlashEnabled = 2'd1,
    CfgFlashLastRow = 2'd2
  } cfg_idx_e;

  // Arithmetic operation selected by the address pair.
  typedef enum logic [2:0] {
    OpMulSS = 3'd0,
    OpMulSU = 3'd1,
    OpMulUS = 3'd2,
    OpMulUU = 3'd3,
    OpDivS  = 3'd4,
    OpDivU  = 3'd5
  } op_sel_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StAccess,
    StRdWait,
    StCrcLo,
    StCrcHi,
    StSwitch,
    StSwWait,
    StOpChk,
    StOpB,
    StOpExec,
    StDiv,
    StWrLo,
    StWrHi,
    StDone
  } state_e;

  // Eight steps of the reflected CRC shift register.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in);
    logic [15:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

endpackage

@@ src/mmaw_ram.sv @@
// ----------------------------------------------------------------------------
// mmaw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mmaw_ram #(
  parameter int Width = 16,
  parameter int Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

@@ src/mapped_math_accelerator_window_top.sv @@
// ----------------------------------------------------------------------------
// mapped_math_accelerator_window_top
// Bus window at 0x8000-0x9FFF backed by an 8K-word RAM, with a CRC-16 port,
// an accelerator on/off switch and a multiply/divide unit.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata {write_data, address}, tuser action
//  m_axis    out        tdata read_data, tuser drives_bus
//  cfg       in         index 0 accel_start, 1 flash_enabled, 2 flash_last_row
//
// An access runs through the RAM sequencer from the idle state in which it is
// accepted; a divide by a nonzero divisor also runs the one-bit-per-cycle
// divider. Every RAM access goes through the single port, one per cycle.
// After reset a clearing pass zeroes all 8192 RAM words; no transaction
// is accepted during it. A stalled output holds its transaction while the
// next input transaction is taken and worked on.
// ----------------------------------------------------------------------------
module mapped_math_accelerator_window_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] address, [31:16] write_data
  input  logic        s_axis_tuser,  // [0] action
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [15:0] read_data
  output logic        m_axis_tuser   // [0] drives_bus
);
  import mmaw_pkg::*;

  state_e state_q, state_d;

  // Configuration and accelerator state.
  logic        flash_en_q, accel_on_q;
  logic [15:0] last_row_q;

  // Latched transaction.
  logic        write_q;
  logic [15:0] addr_q, data_q;

  // Working registers.
  logic [15:0]  rd_q, crc_q, opa_q, res_lo_q, res_hi_q;
  logic         drive_q;
  ram_addr_t    clr_cnt_q;
  logic [15:0]  rem_q;
  logic [15:0]  quo_q, dvs_q;
  logic [3:0]   div_cnt_q;
  logic         neg_q_q, neg_r_q;

  // Output register.
  logic        m_valid_q, m_user_q;
  logic [15:0] m_data_q;

  // RAM port.
  logic        ram_we;
  ram_addr_t   ram_addr;
  logic [15:0] ram_wdata, ram_rdata;

  logic        in_acc, open_win, is_op;
  op_sel_e     op_sel;
  logic [16:0] ext_a, ext_b;
  logic [31:0] product;
  logic [16:0] div_trial;

  // Signed divider results, corrected on the way into the result words.
  logic [15:0] div_q_fix, div_r_fix;
  logic        div_ran_q;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign open_win = (accel_on_q | flash_en_q) & (addr_q[15:13] == WinTop);
  assign is_op    = (addr_q[15:4] == OpPage) & (addr_q[3:0] <= OpLastLow);
  assign op_sel   = op_sel_e'(addr_q[3:1]);

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  mmaw_ram #(
    .Width(16),
    .Depth(RamWords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // Multiplier operands, sign-extended by operation.
  always_comb begin
    ext_a = {1'b0, opa_q};
    ext_b = {1'b0, ram_rdata};
    case (op_sel)
      OpMulSS: begin
        ext_a = {opa_q[15], opa_q};
        ext_b = {ram_rdata[15], ram_rdata};
      end
      OpMulSU: ext_a = {opa_q[15], opa_q};
      OpMulUS: ext_b = {ram_rdata[15], ram_rdata};
      default: ;
    endcase
  end
  assign product   = 32'($signed(ext_a) * $signed(ext_b));
  assign div_trial = {rem_q, quo_q[15]};

  assign div_q_fix = neg_q_q ? 16'(-quo_q) : quo_q;
  assign div_r_fix = neg_r_q ? 16'(-rem_q) : rem_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:  if (clr_cnt_q == ram_addr_t'(RamWords - 1)) state_d = StIdle;
      StIdle:   if (in_acc) state_d = StAccess;
      StAccess: begin
        if (!open_win) state_d = StSwitch;
        else if (!write_q) state_d = StRdWait;
        else if (addr_q == CrcPort) state_d = StCrcLo;
        else state_d = StSwitch;
      end
      StRdWait: state_d = StSwitch;
      StCrcLo:  state_d = StCrcHi;
      StCrcHi:  state_d = StSwitch;
      StSwitch: begin
        if (addr_q == AccOffAddr || addr_q == AccOnAddr) state_d = StSwWait;
        else state_d = StOpChk;
      end
      StSwWait: state_d = StOpChk;
      StOpChk:  state_d = (accel_on_q && is_op) ? StOpB : StDone;
      StOpB:    state_d = StOpExec;
      StOpExec: begin
        if ((op_sel == OpDivS || op_sel == OpDivU) && ram_rdata != 16'h0000) begin
          state_d = StDiv;
        end else begin
          state_d = StWrLo;
        end
      end
      StDiv:    if (div_cnt_q == 4'hF) state_d = StWrLo;
      StWrLo:   state_d = StWrHi;
      StWrHi:   state_d = StDone;
      StDone:   if (!m_valid_q || m_axis_tready) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q[RamAw-1:0];
    ram_wdata = data_q;
    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = 16'h0000;
      end
      StAccess: begin
        if (open_win && write_q) begin
          if (addr_q == CrcPort) ram_addr = CrcWord;
          else ram_we = 1'b1;
        end
      end
      StCrcHi: begin
        ram_we    = 1'b1;
        ram_addr  = CrcWord;
        ram_wdata = crc_byte(crc_q);
      end
      StSwitch: ram_addr = (addr_q == AccOffAddr) ? OffMagicWord : OnMagicWord;
      StOpChk:  ram_addr = OperandBase | ram_addr_t'({addr_q[3:1], 1'b0});
      StOpB:    ram_addr = OperandBase | ram_addr_t'({addr_q[3:1], 1'b1});
      StWrLo: begin
        // A finished divide writes its corrected quotient directly.
        ram_we    = 1'b1;
        ram_addr  = ResLo;
        ram_wdata = div_ran_q ? div_q_fix : res_lo_q;
      end
      StWrHi: begin
        ram_we    = 1'b1;
        ram_addr  = ResHi;
        ram_wdata = res_hi_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StClear;
      clr_cnt_q     <= '0;
      accel_on_q    <= 1'b1;
      flash_en_q    <= 1'b0;
      last_row_q    <= 16'h0000;
      m_valid_q     <= 1'b0;
      div_cnt_q     <= 4'h0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_cnt_q <= clr_cnt_q + ram_addr_t'(1);
      // Configuration writes; accel_start also loads the accelerator state.
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgAccelStart:   accel_on_q <= cfg_data_i[0];
          CfgFlashEnabled: flash_en_q <= cfg_data_i[0];
          CfgFlashLastRow: last_row_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Accelerator switch on a matching magic word.
      if (state_q == StSwWait) begin
        if (addr_q == AccOffAddr && ram_rdata == AccOffMagic) accel_on_q <= 1'b0;
        else if (addr_q == AccOnAddr && ram_rdata == AccOnMagic) accel_on_q <= 1'b1;
      end
      if (state_q == StOpExec) div_cnt_q <= 4'h0;
      else if (state_q == StDiv) div_cnt_q <= div_cnt_q + 4'h1;
      // Output register.
      if (state_q == StDone && (!m_valid_q || m_axis_tready)) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      write_q <= s_axis_tuser;
      addr_q  <= s_axis_tdata[15:0];
      data_q  <= s_axis_tdata[31:16];
      rd_q    <= 16'h0000;
      drive_q <= 1'b0;
    end
    // Read result, with the flash status words.
    if (state_q == StRdWait) begin
      drive_q <= 1'b1;
      if (flash_en_q && addr_q == ZeroAddr) rd_q <= 16'h0000;
      else if (flash_en_q && addr_q == LastRowAddr) rd_q <= last_row_q;
      else rd_q <= ram_rdata;
    end
    if (state_q == StCrcLo) crc_q <= crc_byte(ram_rdata ^ data_q);
    if (state_q == StOpB) opa_q <= ram_rdata;
    // Multiply, divide by zero, or divider set-up.
    if (state_q == StOpExec) begin
      if (op_sel == OpDivS || op_sel == OpDivU) begin
        res_lo_q <= 16'hFFFF;
        res_hi_q <= opa_q;
        rem_q    <= 16'h0000;
        if (op_sel == OpDivS) begin
          quo_q   <= opa_q[15] ? 16'(-opa_q) : opa_q;
          dvs_q   <= ram_rdata[15] ? 16'(-ram_rdata) : ram_rdata;
          neg_q_q <= opa_q[15] ^ ram_rdata[15];
          neg_r_q <= opa_q[15];
        end else begin
          quo_q   <= opa_q;
          dvs_q   <= ram_rdata;
          neg_q_q <= 1'b0;
          neg_r_q <= 1'b0;
        end
      end else begin
        res_lo_q <= product[15:0];
        res_hi_q <= product[31:16];
      end
    end
    // Restoring division, one quotient bit per cycle.
    if (state_q == StDiv) begin
      if (div_trial >= {1'b0, dvs_q}) begin
        rem_q <= 16'(div_trial - {1'b0, dvs_q});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= div_trial[15:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    // The corrected remainder follows the quotient into the result words.
    if (state_q == StWrLo && div_ran_q) res_hi_q <= div_r_fix;
    if (state_q == StDone && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= write_q ? 16'h0000 : rd_q;
      m_user_q <= drive_q;
    end
  end

  // Registered copy of the divider state; it is set in StWrLo when a divide has run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_ran_q <= 1'b0;
    end else begin
      div_ran_q <= (state_q == StDiv);
    end
  end

  // Assertions.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> !s_axis_tready)
    else $error("input accepted during RAM clearing pass");
  a_div_only_by_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (accel_on_q && (op_sel == OpDivS || op_sel == OpDivU)))
    else $error("divider running without a divide operation");
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(m_valid_q)) |-> ($past(state_q) == StDone))
    else $error("result presented outside the final step");
  a_accel_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accel_on_q != $past(accel_on_q) && !$past(cfg_we_i)) |-> ($past(state_q) == StSwWait))
    else $error("accelerator state changed outside the switch step");

endmodule

@@ dv/mapped_math_accelerator_window_top_test.sv @@
// ----------------------------------------------------------------------------
// mapped_math_accelerator_window_top_test
// Self-checking bench for the multiply, divide and CRC window. Bus accesses
// are streamed in, an in-bench model of the window RAM, the accelerator
// switch and the arithmetic unit predicts every response, and a monitor
// compares each response transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mapped_math_accelerator_window_top_test;
  import mmaw_pkg::*;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [15:0] data;
  } bus_access_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        drive;
  } bus_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // [15:0] address, [31:16] write_data
  logic        s_axis_tuser = 1'b0;  // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;  // [15:0] read_data
  logic        m_axis_tuser;  // [0] drives_bus

  mapped_math_accelerator_window_top u_top (.*);

  // Model state of the window.
  logic [15:0] mdl_ram [RamWords];
  logic        mdl_accel_on;
  logic        mdl_flash_en;
  logic [15:0] mdl_last_row;

  bus_access_t pending_accesses[$];
  bus_reply_t  expected_replies[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_recv = 0;
  bit          send_pause = 1'b0;
  int          quiet_cycles = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Multiply or divide selected by the address pair, as the unit does it.
  function automatic void run_arith(input op_sel_e sel);
    logic [15:0] a, b;
    logic signed [31:0] sa, sb, q, r;
    logic [31:0] p;
    a = mdl_ram[OperandBase + 2 * sel];
    b = mdl_ram[OperandBase + 2 * sel + 1];
    sa = $signed({{16{a[15]}}, a});
    sb = $signed({{16{b[15]}}, b});
    case (sel)
      OpMulSS: p = sa * sb;
      OpMulSU: p = sa * $signed({16'h0, b});
      OpMulUS: p = $signed({16'h0, a}) * sb;
      OpMulUU: p = {16'h0, a} * {16'h0, b};
      OpDivS: begin
        if (b == 16'h0) p = {a, 16'hFFFF};
        else begin
          q = sa / sb;
          r = sa - q * sb;
          p = {r[15:0], q[15:0]};
        end
      end
      default: begin
        if (b == 16'h0) p = {a, 16'hFFFF};
        else p = {a % b, a / b};
      end
    endcase
    mdl_ram[ResLo] = p[15:0];
    mdl_ram[ResHi] = p[31:16];
  endfunction

  // Predict the reply to one access and update the model.
  function automatic bus_reply_t predict_reply(input bus_access_t acc);
    bus_reply_t rep;
    logic [15:0] c;
    logic open;
    rep = '0;
    open = (mdl_accel_on || mdl_flash_en) && acc.addr[15:13] == WinTop;
    if (open) begin
      if (!acc.wr) begin
        rep.drive = 1'b1;
        if (mdl_flash_en && acc.addr == ZeroAddr) rep.rdata = 16'h0;
        else if (mdl_flash_en && acc.addr == LastRowAddr) rep.rdata = mdl_last_row;
        else rep.rdata = mdl_ram[acc.addr[12:0]];
      end else if (acc.addr == CrcPort) begin
        c = mdl_ram[CrcWord] ^ acc.data;
        for (int i = 0; i < 16; i++) c = (c >> 1) ^ (c[0] ? CrcPoly : 16'h0);
        mdl_ram[CrcWord] = c;
      end else begin
        mdl_ram[acc.addr[12:0]] = acc.data;
      end
    end
    if (acc.addr == AccOffAddr && mdl_ram[OffMagicWord] == AccOffMagic)
      mdl_accel_on = 1'b0;
    else if (acc.addr == AccOnAddr && mdl_ram[OnMagicWord] == AccOnMagic)
      mdl_accel_on = 1'b1;
    if (mdl_accel_on && acc.addr[15:4] == OpPage && acc.addr[3:0] <= OpLastLow)
      run_arith(op_sel_e'(acc.addr[3:1]));
    return rep;
  endfunction

  // Driver: offers queued accesses, predicting each reply on acceptance.
  always @(posedge clk_i) begin
    bus_access_t acc;
    if (s_axis_tvalid && s_axis_tready) begin
      acc = pending_accesses.pop_front();
      expected_replies.push_back(predict_reply(acc));
    end
    if ((!s_axis_tvalid || s_axis_tready) && rst_ni) begin
      if (pending_accesses.size() > 0 && !send_pause &&
          $urandom_range(99) >= send_idle_pct) begin
        acc = pending_accesses[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {acc.data, acc.addr};
        s_axis_tuser  <= acc.wr;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor and receiver back-pressure.
  always @(posedge clk_i) begin
    bus_reply_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        $error("response transaction with no prediction waiting");
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (m_axis_tdata !== want.rdata) begin
          $error("read_data: expected %h, actual %h", want.rdata, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.drive) begin
          $error("drives_bus: expected %b, actual %b", want.drive, m_axis_tuser);
          errors++;
        end
      end
    end
    if (hold_recv > 0) begin
      hold_recv <= hold_recv - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transaction; allows for the clearing pass.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_access(input logic wr, input logic [15:0] addr,
                              input logic [15:0] data);
    bus_access_t acc;
    acc.wr = wr;
    acc.addr = addr;
    acc.data = data;
    pending_accesses.push_back(acc);
  endtask

  // Wait until every access is through and all replies are in.
  task automatic drain_all();
    while (pending_accesses.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgAccelStart: mdl_accel_on = val[0];
      CfgFlashEnabled: mdl_flash_en = val[0];
      default: mdl_last_row = val;
    endcase
  endtask

  // One random access, mostly aimed at the interesting parts of the window.
  task automatic queue_random();
    logic [15:0] addr;
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) addr = 16'(16'h9F80 + $urandom_range(13));
    else if (pick < 40) addr = CrcPort;
    else if (pick < 50) addr = 16'(16'h8023 + $urandom_range(17));
    else if (pick < 60) addr = 16'(16'h9F80 + $urandom_range(127));
    else if (pick < 80) addr = 16'(16'h8000 + $urandom_range(16'h1FFF));
    else addr = 16'($urandom);
    if (addr[15:13] == WinTop && $urandom_range(99) < 70 && pick >= 60)
      queue_access(1'b1, addr, 16'($urandom));
    else queue_access(1'($urandom_range(1)), addr, 16'($urandom));
  endtask

  initial begin
    for (int i = 0; i < RamWords; i++) mdl_ram[i] = 16'h0;
    mdl_accel_on = 1'b1;
    mdl_flash_en = 1'b0;
    mdl_last_row = 16'h0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: operands at extremes, every operation, divide by zero,
    // signed overflow, CRC, switch words.
    send_idle_pct = 36;
    recv_idle_pct = 72;
    queue_access(1'b1, 16'h9F88, 16'h8000);
    queue_access(1'b1, 16'h9F89, 16'hFFFF);
    queue_access(1'b0, 16'h9F88, 16'h0);
    queue_access(1'b0, 16'h801E, 16'h0);
    queue_access(1'b1, 16'h9F8B, 16'h0000);
    queue_access(1'b1, 16'h9F8A, 16'hFFFF);
    queue_access(1'b0, 16'h9F8E, 16'h0);
    queue_access(1'b0, 16'h9F8F, 16'h0);
    for (int op = 0; op < 6; op++) begin
      queue_access(1'b1, 16'(16'h9F80 + 2 * op), 16'hFFFF);
      queue_access(1'b1, 16'(16'h9F81 + 2 * op), 16'h8001);
    end
    queue_access(1'b0, 16'h9F8F, 16'h0);
    queue_access(1'b1, CrcPort, 16'hFFFF);
    queue_access(1'b0, 16'h9FFD, 16'h0);
    queue_access(1'b0, 16'h9FFC, 16'h0);
    queue_access(1'b1, 16'h8034, AccOffMagic);
    queue_access(1'b0, 16'h8034, 16'h0);
    queue_access(1'b1, 16'h8033, AccOnMagic);
    queue_access(1'b0, 16'h8033, 16'h0);
    queue_access(1'b0, 16'h0000, 16'hFFFF);
    drain_all();

    // Random phases across configurations.
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CfgAccelStart, ph[0] ? 16'h0 : 16'h1);
      write_cfg(CfgFlashEnabled, ph[1] ? 16'h1 : 16'h0);
      write_cfg(CfgFlashLastRow, ph == 2 ? 16'hFFFF : (ph == 3 ? 16'h0 : 16'($urandom)));
      if (ph == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 36;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < 75; i++) queue_random();
      if (ph == 1) begin
        @(posedge clk_i);
        hold_recv <= 300;
      end
      if (ph == 3) begin
        repeat (50) @(posedge clk_i);
        send_pause = 1'b1;
        while (expected_replies.size() > 0 || s_axis_tvalid) @(posedge clk_i);
        send_pause = 1'b0;
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
